// File: hw/rtl/tgi_pkg.sv
// Package for the track gap interpolator: table entry type, widths and angle constants.
// Depends on nothing; imported by track_gap_interpolator_unit, its checker and its testbench.
`default_nettype none
package tgi_pkg;

   localparam int MAX_TAGS   = 1024;
   localparam int SLOT_W     = 10;
   localparam int IDX_W      = $clog2(MAX_TAGS);
   localparam int GAP_LIMIT  = 64;
   localparam int GAP_W      = 7;
   localparam int FRAME_W    = 24;
   localparam int POS_W      = 14;
   localparam int ANG_W      = 16;
   localparam int WIDE_W     = 18;
   localparam int MAG_W      = 15;
   localparam int DIV_STEPS  = MAG_W;
   localparam int LANES      = 3;

   localparam logic signed [WIDE_W-1:0] HALF_TURN = 18'sd18000;
   localparam logic signed [WIDE_W-1:0] FULL_TURN = 18'sd36000;

   localparam logic [1:0] CSR_MAX_GAP  = 2'd0;
   localparam logic [1:0] CSR_MAX_DIST = 2'd1;
   localparam logic [1:0] CSR_MAX_ANG  = 2'd2;

   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_A = 2;

   typedef struct packed {
      logic                    valid;
      logic [FRAME_W-1:0]      frame;
      logic [7:0]              box;
      logic [POS_W-1:0]        x;
      logic [POS_W-1:0]        y;
      logic signed [ANG_W-1:0] heading;
   } entry_type;

   // Reduces a value with magnitude below two turns into (-18000, 18000].
   function automatic logic signed [WIDE_W-1:0] wrap_angle(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] r;
      begin
         if (v >= FULL_TURN) begin
            r = v - FULL_TURN;
         end else if (v <= -FULL_TURN) begin
            r = v + FULL_TURN;
         end else begin
            r = v;
         end
         if (r > HALF_TURN) begin
            r = r - FULL_TURN;
         end else if (r <= -HALF_TURN) begin
            r = r + FULL_TURN;
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/track_gap_interpolator_unit.sv
// Track gap interpolator top level: last-seen table in one synchronous memory,
// gap checks, a three-lane serial divider and the fill generator. Uses tgi_pkg.
// Words are handled one at a time: a new word is taken only once the last word and its
// fills, if any, are done. A filling word waits on the 15-step serial divider and the
// read-modify-write of the table entry, then gives one result per cycle while the receiver
// takes them; the output register holds a result while the receiver stalls.
// Reset: synchronous, active high; afterwards the table is cleared one entry per cycle,
// all 1024 entries, during which no word is accepted (configuration writes are still taken).
`default_nettype none
module track_gap_interpolator_unit
   import tgi_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire [SLOT_W-1:0]        req_tag_slot,
   input  wire [15:0]              req_tag_code,
   input  wire                     req_tag_enabled,
   input  wire [FRAME_W-1:0]       req_death_frame,
   input  wire [FRAME_W-1:0]       req_frame_now,
   input  wire                     req_detected,
   input  wire [7:0]               req_box_id,
   input  wire [POS_W-1:0]         req_pos_x,
   input  wire [POS_W-1:0]         req_pos_y,
   input  wire signed [ANG_W-1:0]  req_heading,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [FRAME_W-1:0]      rsp_fill_frame,
   output logic [15:0]             rsp_fill_tag,
   output logic [7:0]              rsp_fill_box,
   output logic [POS_W-1:0]        rsp_fill_x,
   output logic [POS_W-1:0]        rsp_fill_y,
   output logic signed [ANG_W-1:0] rsp_fill_heading,
   output logic                    rsp_last_fill,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [1:0]               csr_index,
   input  wire [15:0]              csr_data
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_FIX    = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   // Configuration registers. Writes land at any time; the user must write only while idle.
   logic [GAP_W-1:0] max_gap_ff;
   logic [POS_W-1:0] max_dist_ff;
   logic [ANG_W-1:0] max_ang_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gap_ff  <= 7'd10;
         max_dist_ff <= 14'd100;
         max_ang_ff  <= 16'd4500;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_GAP:  max_gap_ff  <= csr_data[GAP_W-1:0];
            CSR_MAX_DIST: max_dist_ff <= csr_data[POS_W-1:0];
            CSR_MAX_ANG:  max_ang_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The last-seen table. One read or one write per cycle is all the sequencer needs,
   // because a word's write-back finishes before the next word's read is issued.
   entry_type           mem [MAX_TAGS];
   entry_type           mem_q_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic                mem_re;

   logic [2:0]          state_ff, state_in;
   logic [IDX_W-1:0]    clr_cnt_ff;

   // Accepted word.
   logic [IDX_W-1:0]        slot_ff;
   logic [15:0]             code_ff;
   logic                    act_ff;
   logic [FRAME_W-1:0]      frame_ff;
   logic [7:0]              box_ff;
   logic [POS_W-1:0]        x_ff;
   logic [POS_W-1:0]        y_ff;
   logic signed [ANG_W-1:0] head_ff;

   logic req_acc;
   logic slot_in_range;
   logic alive;

   assign req_ready     = (state_ff == S_IDLE);
   assign req_acc       = req_valid && req_ready;
   assign slot_in_range = ({7'd0, req_tag_slot} < 17'(MAX_TAGS));
   assign alive         = (req_death_frame == '0) || (req_death_frame > req_frame_now);
   assign mem_re        = req_acc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[req_tag_slot[IDX_W-1:0]];
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = '{valid: 1'b1, frame: frame_ff, box: box_ff, x: x_ff, y: y_ff,
                    heading: head_ff};
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (state_ff == S_LOAD && act_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         slot_ff  <= req_tag_slot[IDX_W-1:0];
         code_ff  <= req_tag_code;
         act_ff   <= slot_in_range && req_tag_enabled && req_detected && alive;
         frame_ff <= req_frame_now;
         box_ff   <= req_box_id;
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         head_ff  <= req_heading;
      end
   end

   // Differences against the stored entry, taken while the entry is written back.
   logic signed [FRAME_W:0]   gap_ff;
   logic                      box_ok_ff;
   logic signed [WIDE_W-1:0]  dx_ff, dy_ff, draw_ff;
   logic [FRAME_W-1:0]        base_frame_ff;
   logic signed [WIDE_W-1:0]  lx_ff, ly_ff, la_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD) begin
         gap_ff        <= $signed({1'b0, frame_ff}) - $signed({1'b0, mem_q_ff.frame});
         box_ok_ff     <= (mem_q_ff.box == box_ff);
         dx_ff         <= $signed({4'd0, x_ff}) - $signed({4'd0, mem_q_ff.x});
         dy_ff         <= $signed({4'd0, y_ff}) - $signed({4'd0, mem_q_ff.y});
         draw_ff       <= WIDE_W'(head_ff) - WIDE_W'(mem_q_ff.heading);
         base_frame_ff <= mem_q_ff.frame;
         lx_ff         <= $signed({4'd0, mem_q_ff.x});
         ly_ff         <= $signed({4'd0, mem_q_ff.y});
         la_ff         <= WIDE_W'(mem_q_ff.heading);
      end
   end

   // Squares and the wrapped angle change, one register stage before the compare.
   logic [29:0]              dx2_ff, dy2_ff, dm2_ff;
   logic signed [WIDE_W-1:0] da_ff;
   logic                     gap_ok_ff;
   logic [GAP_W-1:0]         gmax;
   logic signed [2*WIDE_W-1:0] dx_sq, dy_sq;

   assign gmax  = (max_gap_ff > 7'(GAP_LIMIT)) ? 7'(GAP_LIMIT) : max_gap_ff;
   // The squares are formed at full product width; both fit in 29 bits.
   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_CHECK) begin
         dx2_ff    <= dx_sq[29:0];
         dy2_ff    <= dy_sq[29:0];
         dm2_ff    <= 30'({16'd0, max_dist_ff} * {16'd0, max_dist_ff});
         da_ff     <= wrap_angle(draw_ff);
         gap_ok_ff <= (gap_ff > 25'sd1) && (gap_ff <= $signed({18'd0, gmax}));
      end
   end

   logic              fill_ok;
   logic [ANG_W:0]    abs_da;
   assign abs_da  = da_ff[WIDE_W-1] ? 17'(-da_ff) : 17'(da_ff);
   assign fill_ok = gap_ok_ff && box_ok_ff && ({1'b0, dx2_ff} + {1'b0, dy2_ff} <= {1'b0, dm2_ff})
                    && (abs_da <= {1'b0, max_ang_ff});

   // Three-lane restoring divider: each step of the serial unit yields one quotient bit
   // of |dx|/n, |dy|/n and |da|/n.
   logic [GAP_W-1:0]  n_ff;
   logic [MAG_W-1:0]  dvd_ff [LANES];
   logic [MAG_W-1:0]  quo_ff [LANES];
   logic [GAP_W-1:0]  rem_ff [LANES];
   logic              neg_ff [LANES];
   logic [3:0]        div_cnt_ff;

   logic signed [WIDE_W-1:0] diff_sel [LANES];
   assign diff_sel[LANE_X] = dx_ff;
   assign diff_sel[LANE_Y] = dy_ff;
   assign diff_sel[LANE_A] = da_ff;

   // Running interpolation value kept as quotient and remainder of the numerator over n.
   logic signed [WIDE_W-1:0] qd_ff [LANES];
   logic [GAP_W-1:0]         rd_ff [LANES];
   logic signed [WIDE_W-1:0] run_q_ff [LANES];
   logic [GAP_W-1:0]         run_r_ff [LANES];
   logic signed [WIDE_W-1:0] step_q [LANES];
   logic [GAP_W-1:0]         step_r [LANES];
   logic signed [WIDE_W-1:0] step_v [LANES];
   logic [GAP_W-1:0]         j_ff;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         logic [GAP_W-1:0] rsum;
         logic             carry;
         rsum      = run_r_ff[k] + rd_ff[k];
         carry     = (rsum >= n_ff);
         step_r[k] = carry ? rsum - n_ff : rsum;
         step_q[k] = run_q_ff[k] + qd_ff[k] + WIDE_W'(carry);
         // Truncation toward zero for a negative numerator with a remainder.
         step_v[k] = (step_q[k] < 0 && step_r[k] != '0) ? step_q[k] + 18'sd1 : step_q[k];
      end
   end

   logic load_out;
   logic last_now;
   assign load_out = (state_ff == S_EMIT) && (!rsp_valid || rsp_ready);
   assign last_now = (j_ff == n_ff - 7'd1);

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_DECIDE: begin
            n_ff       <= gap_ff[GAP_W-1:0];
            div_cnt_ff <= '0;
            for (int k = 0; k < LANES; k++) begin
               neg_ff[k] <= diff_sel[k][WIDE_W-1];
               dvd_ff[k] <= diff_sel[k][WIDE_W-1] ? MAG_W'(-diff_sel[k])
                                                   : diff_sel[k][MAG_W-1:0];
               rem_ff[k] <= '0;
               quo_ff[k] <= '0;
            end
         end
         S_DIV: begin
            div_cnt_ff <= div_cnt_ff + 4'd1;
            for (int k = 0; k < LANES; k++) begin
               logic [GAP_W-1:0] trial;
               trial = {rem_ff[k][GAP_W-2:0], dvd_ff[k][MAG_W-1]};
               dvd_ff[k] <= {dvd_ff[k][MAG_W-2:0], 1'b0};
               if (trial >= n_ff) begin
                  rem_ff[k] <= trial - n_ff;
                  quo_ff[k] <= {quo_ff[k][MAG_W-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= trial;
                  quo_ff[k] <= {quo_ff[k][MAG_W-2:0], 1'b0};
               end
            end
         end
         S_FIX: begin
            j_ff <= 7'd1;
            run_q_ff[LANE_X] <= lx_ff;
            run_q_ff[LANE_Y] <= ly_ff;
            run_q_ff[LANE_A] <= la_ff;
            for (int k = 0; k < LANES; k++) begin
               run_r_ff[k] <= '0;
               // Floor division: a negative difference with a remainder rounds down.
               if (!neg_ff[k]) begin
                  qd_ff[k] <= $signed({3'd0, quo_ff[k]});
                  rd_ff[k] <= rem_ff[k];
               end else if (rem_ff[k] == '0) begin
                  qd_ff[k] <= -$signed({3'd0, quo_ff[k]});
                  rd_ff[k] <= '0;
               end else begin
                  qd_ff[k] <= -$signed({3'd0, quo_ff[k]}) - 18'sd1;
                  rd_ff[k] <= n_ff - rem_ff[k];
               end
            end
         end
         S_EMIT: begin
            if (load_out) begin
               j_ff <= j_ff + 7'd1;
               for (int k = 0; k < LANES; k++) begin
                  run_q_ff[k] <= step_q[k];
                  run_r_ff[k] <= step_r[k];
               end
            end
         end
         default: ;
      endcase
   end

   // Output register: holds one result word until it is taken.
   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_fill_frame   <= base_frame_ff + FRAME_W'(j_ff);
         rsp_fill_tag     <= code_ff;
         rsp_fill_box     <= box_ff;
         rsp_fill_x       <= step_v[LANE_X][POS_W-1:0];
         rsp_fill_y       <= step_v[LANE_Y][POS_W-1:0];
         rsp_fill_heading <= ANG_W'(wrap_angle(step_v[LANE_A]));
         rsp_last_fill    <= last_now;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_cnt_ff == IDX_W'(MAX_TAGS - 1)) state_in = S_IDLE;
         S_IDLE:   if (req_acc) state_in = S_LOAD;
         S_LOAD:   state_in = (act_ff && mem_q_ff.valid) ? S_CHECK : S_IDLE;
         S_CHECK:  state_in = S_DECIDE;
         S_DECIDE: state_in = fill_ok ? S_DIV : S_IDLE;
         S_DIV:    if (div_cnt_ff == 4'(DIV_STEPS - 1)) state_in = S_FIX;
         S_FIX:    state_in = S_EMIT;
         S_EMIT:   if (load_out && last_now) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // The clearing pass blocks input and never produces results.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!req_ready && !rsp_valid_ff))
      else $error("word accepted or result shown during table clear");

   // The final result of a run returns the sequencer to idle.
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load_out && last_now) |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_last_fill))
      else $error("run did not end after its last result");

   // A run only starts with a gap of at least two frames.
   a_gap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIX) |-> (n_ff > 7'd1 && n_ff <= 7'(GAP_LIMIT)))
      else $error("fill run started with an illegal gap");

endmodule
`default_nettype wire

// File: dv/track_gap_interpolator_checker.sv
// Checker for the track gap interpolator: watches the detection, fill and register channels,
// predicts the fills of each accepted detection and compares. Uses tgi_pkg.
`timescale 1ns / 100ps
module track_gap_interpolator_checker
   import tgi_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  wire [SLOT_W-1:0]        req_tag_slot,
   input  wire [15:0]              req_tag_code,
   input  wire                     req_tag_enabled,
   input  wire [FRAME_W-1:0]       req_death_frame,
   input  wire [FRAME_W-1:0]       req_frame_now,
   input  wire                     req_detected,
   input  wire [7:0]               req_box_id,
   input  wire [POS_W-1:0]         req_pos_x,
   input  wire [POS_W-1:0]         req_pos_y,
   input  wire signed [ANG_W-1:0]  req_heading,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  wire [FRAME_W-1:0]       rsp_fill_frame,
   input  wire [15:0]              rsp_fill_tag,
   input  wire [7:0]               rsp_fill_box,
   input  wire [POS_W-1:0]         rsp_fill_x,
   input  wire [POS_W-1:0]         rsp_fill_y,
   input  wire signed [ANG_W-1:0]  rsp_fill_heading,
   input  wire                     rsp_last_fill,
   input  wire                     csr_valid,
   input  wire                     csr_ready,
   input  wire [1:0]               csr_index,
   input  wire [15:0]              csr_data,
   output int                      mismatch_count,
   output int                      pending_fills
);

   typedef struct {
      logic [FRAME_W-1:0]      frame;
      logic [15:0]             tag;
      logic [7:0]              box;
      logic [POS_W-1:0]        x;
      logic [POS_W-1:0]        y;
      logic signed [ANG_W-1:0] heading;
      logic                    last;
   } fill_type;

   fill_type expected_fills[$];

   logic [GAP_W-1:0]  gap_limit_reg;
   logic [POS_W-1:0]  distance_limit_reg;
   logic [ANG_W-1:0]  angle_limit_reg;

   logic                    seen_valid[MAX_TAGS];
   logic [FRAME_W-1:0]      seen_frame[MAX_TAGS];
   logic [7:0]              seen_box[MAX_TAGS];
   logic [POS_W-1:0]        seen_x[MAX_TAGS];
   logic [POS_W-1:0]        seen_y[MAX_TAGS];
   logic signed [ANG_W-1:0] seen_heading[MAX_TAGS];

   assign pending_fills = expected_fills.size();

   function automatic longint turn_reduce(input longint v);
      longint r;
      r = v % 36000;
      if (r > 18000) r -= 36000;
      if (r <= -18000) r += 36000;
      return r;
   endfunction

   // Works out the fills of one accepted detection and updates the table entry.
   task automatic predict_fills();
      int      s;
      longint  gap, gmax, lx, ly, la, dx, dy, dm, da, nx, ny, na;
      fill_type f;
      s = req_tag_slot;
      if (!req_tag_enabled || !req_detected) return;
      if (!(req_death_frame == 0 || req_death_frame > req_frame_now)) return;
      if (seen_valid[s]) begin
         gap  = longint'(req_frame_now) - longint'(seen_frame[s]);
         gmax = (gap_limit_reg > GAP_LIMIT) ? GAP_LIMIT : longint'(gap_limit_reg);
         lx   = seen_x[s];
         ly   = seen_y[s];
         la   = seen_heading[s];
         dx   = longint'(req_pos_x) - lx;
         dy   = longint'(req_pos_y) - ly;
         dm   = distance_limit_reg;
         da   = turn_reduce(longint'(req_heading) - la);
         if (gap > 1 && gap <= gmax && seen_box[s] == req_box_id &&
             dx * dx + dy * dy <= dm * dm && (da < 0 ? -da : da) <= angle_limit_reg) begin
            for (longint j = 1; j < gap; j++) begin
               nx = (lx * gap + j * dx) / gap;
               ny = (ly * gap + j * dy) / gap;
               na = turn_reduce((la * gap + j * da) / gap);
               f.frame   = seen_frame[s] + j[FRAME_W-1:0];
               f.tag     = req_tag_code;
               f.box     = req_box_id;
               f.x       = nx[POS_W-1:0];
               f.y       = ny[POS_W-1:0];
               f.heading = na[ANG_W-1:0];
               f.last    = (j == gap - 1);
               expected_fills.insert(expected_fills.size(), f);
            end
         end
      end
      seen_valid[s]   = 1'b1;
      seen_frame[s]   = req_frame_now;
      seen_box[s]     = req_box_id;
      seen_x[s]       = req_pos_x;
      seen_y[s]       = req_pos_y;
      seen_heading[s] = req_heading;
   endtask

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: fill mismatch: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      fill_type f;
      if (reset) begin
         gap_limit_reg      <= 7'd10;
         distance_limit_reg <= 14'd100;
         angle_limit_reg    <= 16'd4500;
         for (int i = 0; i < MAX_TAGS; i++) seen_valid[i] = 1'b0;
         expected_fills.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_GAP: begin
                  gap_limit_reg <= csr_data[GAP_W-1:0];
               end
               CSR_MAX_DIST: begin
                  distance_limit_reg <= csr_data[POS_W-1:0];
               end
               CSR_MAX_ANG: begin
                  angle_limit_reg <= csr_data;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) predict_fills();
         if (rsp_valid && rsp_ready) begin
            if (expected_fills.size() == 0) begin
               note_mismatch($sformatf("unexpected word frame %0d tag %0d",
                                       rsp_fill_frame, rsp_fill_tag));
            end else begin
               f = expected_fills.pop_front();
               if (rsp_fill_frame !== f.frame || rsp_fill_tag !== f.tag ||
                   rsp_fill_box !== f.box || rsp_fill_x !== f.x || rsp_fill_y !== f.y ||
                   rsp_fill_heading !== f.heading || rsp_last_fill !== f.last) begin
                  note_mismatch($sformatf(
                     "exp %0d/%0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                     f.frame, f.tag, f.box, f.x, f.y, f.heading, f.last,
                     rsp_fill_frame, rsp_fill_tag, rsp_fill_box, rsp_fill_x, rsp_fill_y,
                     rsp_fill_heading, rsp_last_fill));
               end
            end
         end
      end
   end

   initial mismatch_count = 0;

endmodule

// File: dv/track_gap_interpolator_unit_test.sv
// Testbench top for track_gap_interpolator_unit: drives detections, register writes and
// fill back-pressure, and gives the verdict. Uses tgi_pkg and track_gap_interpolator_checker.
`timescale 1ns / 100ps
module track_gap_interpolator_unit_test
   import tgi_pkg::*;
();

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [SLOT_W-1:0]       req_tag_slot = '0;
   logic [15:0]             req_tag_code = '0;
   logic                    req_tag_enabled = 1'b0;
   logic [FRAME_W-1:0]      req_death_frame = '0;
   logic [FRAME_W-1:0]      req_frame_now = '0;
   logic                    req_detected = 1'b0;
   logic [7:0]              req_box_id = '0;
   logic [POS_W-1:0]        req_pos_x = '0;
   logic [POS_W-1:0]        req_pos_y = '0;
   logic signed [ANG_W-1:0] req_heading = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [FRAME_W-1:0]      rsp_fill_frame;
   logic [15:0]             rsp_fill_tag;
   logic [7:0]              rsp_fill_box;
   logic [POS_W-1:0]        rsp_fill_x;
   logic [POS_W-1:0]        rsp_fill_y;
   logic signed [ANG_W-1:0] rsp_fill_heading;
   logic                    rsp_last_fill;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index = '0;
   logic [15:0]             csr_data = '0;
   int                      mismatch_count;
   int                      pending_fills;

   // One detection word as the sender sees it.
   typedef struct {
      logic [SLOT_W-1:0]       slot;
      logic [15:0]             code;
      logic                    enabled;
      logic [FRAME_W-1:0]      death;
      logic [FRAME_W-1:0]      frame;
      logic                    detected;
      logic [7:0]              box;
      logic [POS_W-1:0]        x;
      logic [POS_W-1:0]        y;
      logic signed [ANG_W-1:0] heading;
   } detection_type;

   localparam int TRACKS = 16;
   localparam int IDLE_LIMIT = 6000;

   // The sender's own idea of where each tracked tag was last seen, used only to
   // build detections, most of which pass the gap, box, distance and angle checks.
   int track_frame[TRACKS];
   int track_box[TRACKS];
   int track_x[TRACKS];
   int track_y[TRACKS];
   int track_heading[TRACKS];

   int gap_setting, distance_setting, angle_setting;
   int burst_left = 0;
   int hold_requests = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   track_gap_interpolator_unit dut (.*);

   track_gap_interpolator_checker checker_inst (.*);

   // The receiver follows a slowly changing pattern of its own: stretches of
   // full readiness, random stalls and short periodic stalls. When the stimulus
   // asks for it, it holds off for a long stretch so the fill path backs up.
   always @(negedge clock) begin : receiver
      static int cycle_count = 0;
      static int hold_left = 0;
      static int holds_served = 0;
      cycle_count++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served < hold_requests) begin
         holds_served++;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else begin
         case ((cycle_count / 200) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(1, 0) == 1);
            2: rsp_ready <= ((cycle_count % 7) > 2);
            default: rsp_ready <= ($urandom_range(9, 0) < 8);
         endcase
      end
   end

   // The watchdog counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Writes one register; called at a falling edge and returns at one.
   task automatic write_register(input logic [1:0] index, input int value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value[15:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits for every predicted fill, then lets a word without fill drain as well.
   task automatic wait_until_idle();
      wait (pending_fills == 0);
      @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic apply_settings(input int gap_value, input int dist_value, input int ang_value);
      // The last word of a burst is still offered; withdraw it so it is not taken twice.
      req_valid = 1'b0;
      wait_until_idle();
      write_register(CSR_MAX_GAP, gap_value);
      write_register(CSR_MAX_DIST, dist_value);
      write_register(CSR_MAX_ANG, ang_value);
      gap_setting      = (gap_value > GAP_LIMIT) ? GAP_LIMIT : gap_value;
      distance_setting = dist_value;
      angle_setting    = ang_value;
   endtask

   // Offers one word, holds it until taken, then maybe opens a gap before the next.
   task automatic offer(input detection_type w);
      req_valid       = 1'b1;
      req_tag_slot    = w.slot;
      req_tag_code    = w.code;
      req_tag_enabled = w.enabled;
      req_death_frame = w.death;
      req_frame_now   = w.frame;
      req_detected    = w.detected;
      req_box_id      = w.box;
      req_pos_x       = w.x;
      req_pos_y       = w.y;
      req_heading     = w.heading;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // A burst has ended: pause for a random gap, and pick the next burst length.
         int pause;
         pause = $urandom_range(6, 0);
         if (pause > 0) begin
            req_valid = 1'b0;
            repeat (pause) @(negedge clock);
         end
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 0);
      end
   endtask

   function automatic detection_type make_detection(input int slot, input int frame,
                                                    input int box, input int x, input int y,
                                                    input int heading);
      detection_type w;
      w.slot     = slot[SLOT_W-1:0];
      w.code     = 16'(slot * 7 + 3);
      w.enabled  = 1'b1;
      w.death    = '0;
      w.frame    = frame[FRAME_W-1:0];
      w.detected = 1'b1;
      w.box      = box[7:0];
      w.x        = x[POS_W-1:0];
      w.y        = y[POS_W-1:0];
      w.heading  = heading[ANG_W-1:0];
      return w;
   endfunction

   function automatic int clamp_position(input int v);
      return (v < 0) ? 0 : ((v > 16383) ? 16383 : v);
   endfunction

   // Builds the next detection of a tracked tag; most pass all checks.
   function automatic detection_type next_track_detection(input int t);
      detection_type w;
      int gap, d, a, heading;
      if ($urandom_range(9, 0) < 8) gap = $urandom_range(gap_setting, 2);
      else gap = $urandom_range(gap_setting + 3, 0) - 1;
      d = distance_setting / 2;
      a = (angle_setting > 18000) ? 18000 : angle_setting;
      heading = track_heading[t] + $urandom_range(2 * a, 0) - a;
      if (heading > 18000) heading -= 36000;
      if (heading <= -18000) heading += 36000;
      w = make_detection(t * 65, track_frame[t] + gap, track_box[t],
                         clamp_position(track_x[t] + $urandom_range(2 * d, 0) - d),
                         clamp_position(track_y[t] + $urandom_range(2 * d, 0) - d), heading);
      if ($urandom_range(19, 0) == 0) w.box = 8'($urandom);
      if ($urandom_range(24, 0) == 0) w.heading = ANG_W'($urandom);
      w.code = 16'($urandom);
      if ($urandom_range(3, 0) == 0) w.death = FRAME_W'(w.frame + $urandom_range(1000, 1));
      case ($urandom_range(29, 0))
         0: w.enabled = 1'b0;
         1: w.detected = 1'b0;
         2: w.death = FRAME_W'(w.frame - $urandom_range(5, 0));
         default: begin
         end
      endcase
      return w;
   endfunction

   function automatic detection_type noise_detection();
      detection_type w;
      w.slot     = SLOT_W'($urandom);
      w.code     = 16'($urandom);
      w.enabled  = 1'($urandom);
      w.death    = ($urandom_range(1, 0) == 1) ? 24'd0 : 24'($urandom);
      w.frame    = FRAME_W'($urandom);
      w.detected = 1'($urandom);
      w.box      = 8'($urandom);
      w.x        = POS_W'($urandom);
      w.y        = POS_W'($urandom);
      w.heading  = ANG_W'($urandom);
      return w;
   endfunction

   initial begin : stimulus
      detection_type w;
      int phase_gap[6]  = '{10, 64, 1, 127, 5, 20};
      int phase_dist[6] = '{100, 16383, 0, 50, 300, 2000};
      int phase_ang[6]  = '{4500, 36000, 0, 1000, 9000, 18000};
      int t;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      apply_settings(phase_gap[0], phase_dist[0], phase_ang[0]);

      // Directed part: a fresh entry, a clean fill, then each way a fill is refused.
      offer(make_detection(3, 100, 7, 50, 60, 0));
      offer(make_detection(3, 104, 7, 58, 52, 400));      // fills three frames
      offer(make_detection(3, 104, 7, 58, 52, 400));      // same frame again
      offer(make_detection(3, 90, 7, 58, 52, 400));       // frame goes backwards
      offer(make_detection(3, 91, 7, 60, 52, 400));       // gap of one
      offer(make_detection(3, 95, 9, 60, 52, 400));       // box changed
      offer(make_detection(3, 97, 9, 260, 52, 400));      // moved too far
      offer(make_detection(3, 100, 9, 260, 52, 9400));    // turned too far
      offer(make_detection(3, 103, 9, 262, 55, 17900));
      offer(make_detection(3, 108, 9, 266, 58, -17900));  // fill across the half turn
      offer(make_detection(3, 118, 9, 250, 40, -17000));  // gap equal to the limit
      offer(make_detection(3, 129, 9, 250, 40, -17000));  // gap just over the limit
      w = make_detection(3, 135, 9, 251, 41, -17001);
      w.enabled = 1'b0;
      offer(w);
      w.enabled = 1'b1;
      w.detected = 1'b0;
      offer(w);
      w.detected = 1'b1;
      w.death = 24'd135;                                   // dies on this very frame
      offer(w);
      w.death = 24'd136;                                   // still alive, fills
      offer(w);
      offer(make_detection(3, 138, 9, 251, 41, -32768));  // heading outside its range
      offer(make_detection(3, 141, 9, 251, 41, 32767));
      offer(make_detection(1023, 16777210, 255, 16383, 16383, 18000));
      w = make_detection(1023, 16777215, 255, 16300, 16320, 17000);
      w.code = 16'hFFFF;
      w.death = 24'd0;
      offer(w);
      offer(make_detection(1023, 0, 255, 16383, 16383, 18000)); // frame wraps to zero
      offer(make_detection(0, 5, 0, 0, 0, -17999));
      offer(make_detection(0, 9, 0, 3, 0, -17000));

      for (int i = 0; i < TRACKS; i++) begin
         track_frame[i]   = $urandom_range(100000, 1000);
         track_box[i]     = $urandom_range(255, 0);
         track_x[i]       = $urandom_range(16383, 0);
         track_y[i]       = $urandom_range(16383, 0);
         track_heading[i] = $urandom_range(36000, 1) - 18000;
      end

      // Random part: several register settings, each with well-formed tracks and some noise.
      for (int phase = 0; phase < 6; phase++) begin
         apply_settings(phase_gap[phase], phase_dist[phase], phase_ang[phase]);
         if (phase == 1 || phase == 4) hold_requests++;
         repeat ((phase == 1 || phase == 3) ? 45 : 80) begin
            if ($urandom_range(9, 0) == 0) begin
               offer(noise_detection());
            end else begin
               t = $urandom_range(TRACKS - 1, 0);
               w = next_track_detection(t);
               offer(w);
               if (w.enabled && w.detected && (w.death == 0 || w.death > w.frame)) begin
                  track_frame[t]   = w.frame;
                  track_box[t]     = w.box;
                  track_x[t]       = w.x;
                  track_y[t]       = w.y;
                  track_heading[t] = w.heading;
               end
            end
         end
      end

      req_valid = 1'b0;
      wait (pending_fills == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_fills == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
